### rtl/srbp_pkg.sv
// Package for the sonar row beam profile block.
// Field widths, configuration register indexes, reset values and fixed constants.
// No dependencies.
`default_nettype none

package srbp_pkg;

    localparam int MAX_BEAMS_DEF  = 128;
    localparam int MAX_WINDOW_DEF = 16;

    localparam int AMP_W       = 8;
    localparam int BEAMS_W     = 8;
    localparam int WINDOW_W    = 5;
    localparam int SCALE_W     = 15;
    localparam int DB_W        = 15;
    localparam int BEAM_OUT_W  = 7;
    localparam int ANGLE_W     = 10;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_OF_BEAMS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AVG_BEAMS       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AVG_SCALE       = 2'd2;

    localparam logic [BEAMS_W-1:0]  BEAMS_RESET = 8'd96;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 5'd4;
    localparam logic [SCALE_W-1:0]  SCALE_RESET = 15'd6143;

    // Rows of at least this many beams use the narrow beam spacing.
    localparam int WIDE_BEAM_LIMIT = 96;
    // Raw amplitude to Q7.8 dB.
    localparam int DB_PER_COUNT    = 96;
    localparam int AMP_MAX         = 255;
    localparam int DB_MAX          = 32767;

endpackage

`default_nettype wire

### rtl/srbp_row_acc.sv
// Input register and per-row accumulation for the sonar row beam profile.
// Tracks the beam index, the centre window sum and peak, and the strongest beam.
// Depends on srbp_pkg.
`default_nettype none

module srbp_row_acc #(
    parameter int MAX_BEAMS  = srbp_pkg::MAX_BEAMS_DEF,
    parameter int MAX_WINDOW = srbp_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [srbp_pkg::AMP_W-1:0]      amplitude,
    input  wire logic [srbp_pkg::BEAMS_W-1:0]    number_of_beams,
    input  wire logic [srbp_pkg::WINDOW_W-1:0]   avg_beams,
    output logic                                 rec_valid,
    input  wire logic                            rec_ready,
    output logic [$clog2(MAX_WINDOW*srbp_pkg::AMP_MAX+1)-1:0] rec_sum,
    output logic [srbp_pkg::AMP_W-1:0]           rec_peak,
    output logic [$clog2(MAX_BEAMS)-1:0]         rec_best,
    output logic [$clog2(MAX_BEAMS)-1:0]         rec_half,
    output logic                                 rec_wide
);

    localparam int CW   = $clog2(MAX_BEAMS);
    localparam int NW   = $clog2(MAX_BEAMS + 1);
    localparam int WW   = $clog2(MAX_WINDOW + 1);
    localparam int ABW  = (WW > srbp_pkg::WINDOW_W) ? WW : srbp_pkg::WINDOW_W;
    localparam int SW   = $clog2(MAX_WINDOW * srbp_pkg::AMP_MAX + 1);
    localparam int PW   = ((NW > ABW) ? NW : ABW) + 1;

    logic                         a_valid_reg;
    logic [srbp_pkg::AMP_W-1:0]   a_amp_reg;
    logic [CW-1:0]                count_reg;
    logic [srbp_pkg::AMP_W-1:0]   best_amp_reg;
    logic [CW-1:0]                best_beam_reg;
    logic [SW-1:0]                sum_reg;
    logic [srbp_pkg::AMP_W-1:0]   peak_reg;

    logic                         b_valid_reg;
    logic [SW-1:0]                b_sum_reg;
    logic [srbp_pkg::AMP_W-1:0]   b_peak_reg;
    logic [CW-1:0]                b_best_reg;
    logic [CW-1:0]                b_half_reg;
    logic                         b_wide_reg;

    logic [NW-1:0]                nb_eff;
    logic [ABW-1:0]               ab_eff;
    logic [NW-1:0]                half_nb;
    logic [ABW-1:0]               half_ab;
    logic [PW-1:0]                win_pos;
    logic                         in_window;
    logic                         row_end;
    logic                         b_free;
    logic                         a_go;
    logic [SW-1:0]                sum_next;
    logic [srbp_pkg::AMP_W-1:0]   peak_next;
    logic                         take_best;
    logic [srbp_pkg::AMP_W-1:0]   best_amp_next;
    logic [CW-1:0]                best_beam_next;

    always_comb
    begin
        if (number_of_beams == '0)
        begin
            nb_eff = NW'(1);
        end
        else if (32'(number_of_beams) > 32'(MAX_BEAMS))
        begin
            nb_eff = NW'(MAX_BEAMS);
        end
        else
        begin
            nb_eff = NW'(number_of_beams);
        end

        if (32'(avg_beams) > 32'(MAX_WINDOW))
        begin
            ab_eff = ABW'(MAX_WINDOW);
        end
        else
        begin
            ab_eff = ABW'(avg_beams);
        end
    end

    assign half_nb = nb_eff >> 1;
    assign half_ab = ab_eff >> 1;

    // The window runs from half_nb - half_ab for ab_eff beams; both bounds are
    // moved by half_ab so the test stays unsigned.
    assign win_pos   = PW'(count_reg) + PW'(half_ab);
    assign in_window = (win_pos >= PW'(half_nb)) && (win_pos < PW'(half_nb) + PW'(ab_eff));
    assign row_end   = (PW'(count_reg) + PW'(1)) >= PW'(nb_eff);

    assign b_free   = !b_valid_reg || rec_ready;
    assign a_go     = a_valid_reg && (!row_end || b_free);
    assign s_tready = !a_valid_reg || a_go;

    assign sum_next  = in_window ? (sum_reg + SW'(a_amp_reg)) : sum_reg;
    assign peak_next = (in_window && (a_amp_reg > peak_reg)) ? a_amp_reg : peak_reg;
    assign take_best = (count_reg == '0) || (a_amp_reg > best_amp_reg);
    assign best_amp_next  = take_best ? a_amp_reg : best_amp_reg;
    assign best_beam_next = take_best ? count_reg : best_beam_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            count_reg     <= '0;
            best_amp_reg  <= '0;
            best_beam_reg <= '0;
            sum_reg       <= '0;
            peak_reg      <= '0;
            b_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                a_valid_reg <= s_tvalid;
            end

            if (a_go)
            begin
                if (row_end)
                begin
                    count_reg     <= '0;
                    best_amp_reg  <= '0;
                    best_beam_reg <= '0;
                    sum_reg       <= '0;
                    peak_reg      <= '0;
                end
                else
                begin
                    count_reg     <= count_reg + CW'(1);
                    best_amp_reg  <= best_amp_next;
                    best_beam_reg <= best_beam_next;
                    sum_reg       <= sum_next;
                    peak_reg      <= peak_next;
                end
            end

            if (a_go && row_end)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (rec_ready)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            a_amp_reg <= amplitude;
        end
        if (a_go && row_end)
        begin
            b_sum_reg  <= sum_next;
            b_peak_reg <= peak_next;
            b_best_reg <= best_beam_next;
            b_half_reg <= CW'(half_nb);
            b_wide_reg <= 32'(nb_eff) >= 32'(srbp_pkg::WIDE_BEAM_LIMIT);
        end
    end

    assign rec_valid = b_valid_reg;
    assign rec_sum   = b_sum_reg;
    assign rec_peak  = b_peak_reg;
    assign rec_best  = b_best_reg;
    assign rec_half  = b_half_reg;
    assign rec_wide  = b_wide_reg;

    // A closed row always starts the next one from beam zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_go && row_end) |=> (count_reg == '0))
    else $error("row state not cleared after the last beam");

    // Inside a row the beam index advances by one per processed beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_go && !row_end) |=> (count_reg == $past(count_reg) + CW'(1)))
    else $error("beam index did not advance");

    // The window sum holds the window peak, so it can never be below it.
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (b_sum_reg >= SW'(b_peak_reg)))
    else $error("window sum below window peak");

endmodule

`default_nettype wire

### rtl/srbp_result.sv
// Result stage of the sonar row beam profile: mean and peak in dB, beam angle.
// Holds the output register of the master-side stream.
// Depends on srbp_pkg.
`default_nettype none

module srbp_result #(
    parameter int MAX_BEAMS  = srbp_pkg::MAX_BEAMS_DEF,
    parameter int MAX_WINDOW = srbp_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            rec_valid,
    output logic                                 rec_ready,
    input  wire logic [$clog2(MAX_WINDOW*srbp_pkg::AMP_MAX+1)-1:0] rec_sum,
    input  wire logic [srbp_pkg::AMP_W-1:0]      rec_peak,
    input  wire logic [$clog2(MAX_BEAMS)-1:0]    rec_best,
    input  wire logic [$clog2(MAX_BEAMS)-1:0]    rec_half,
    input  wire logic                            rec_wide,
    input  wire logic [srbp_pkg::SCALE_W-1:0]    avg_scale,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // center_mean_db[14:0], center_max_db[29:15], strongest_beam[36:30],
    // strongest_angle[46:37], zero fill [47]
    output logic [srbp_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int CW   = $clog2(MAX_BEAMS);
    localparam int SW   = $clog2(MAX_WINDOW * srbp_pkg::AMP_MAX + 1);
    localparam int PRW  = SW + srbp_pkg::SCALE_W;
    localparam int MW   = PRW - 8;
    localparam int AW   = (CW + 5 > srbp_pkg::ANGLE_W) ? CW + 5 : srbp_pkg::ANGLE_W;
    localparam int DB_W = srbp_pkg::DB_W;
    localparam logic [DB_W-1:0] PEAK_DB_MAX = DB_W'(srbp_pkg::AMP_MAX * srbp_pkg::DB_PER_COUNT);

    logic                                out_valid_reg;
    logic [DB_W-1:0]                     mean_db_reg;
    logic [DB_W-1:0]                     max_db_reg;
    logic [srbp_pkg::BEAM_OUT_W-1:0]     beam_reg;
    logic [srbp_pkg::ANGLE_W-1:0]        angle_reg;

    logic [PRW-1:0]                      product;
    logic [MW-1:0]                       mean_wide;
    logic [DB_W-1:0]                     mean_db;
    logic [DB_W-1:0]                     max_db;
    logic signed [AW-1:0]                beam_offset;
    logic signed [AW-1:0]                offset_x3;
    logic signed [AW-1:0]                angle_wide;
    logic                                take;

    assign rec_ready = !out_valid_reg || m_tready;
    assign take      = rec_valid && rec_ready;

    assign product   = PRW'(rec_sum) * PRW'(avg_scale);
    assign mean_wide = product[PRW-1:8];
    assign mean_db   = (mean_wide > MW'(srbp_pkg::DB_MAX)) ? DB_W'(srbp_pkg::DB_MAX)
                                                           : DB_W'(mean_wide);
    assign max_db    = DB_W'(rec_peak) * DB_W'(srbp_pkg::DB_PER_COUNT);

    // 0.3 degree per beam on wide rows, 0.6 on narrow ones, in tenths.
    assign beam_offset = $signed(AW'(rec_best)) - $signed(AW'(rec_half));
    assign offset_x3   = beam_offset + (beam_offset <<< 1);
    assign angle_wide  = rec_wide ? offset_x3 : (offset_x3 <<< 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rec_ready)
        begin
            out_valid_reg <= rec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mean_db_reg <= mean_db;
            max_db_reg  <= max_db;
            beam_reg    <= srbp_pkg::BEAM_OUT_W'(rec_best);
            angle_reg   <= angle_wide[srbp_pkg::ANGLE_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, angle_reg, beam_reg, max_db_reg, mean_db_reg};

    // The peak in dB comes from one amplitude byte and stays in its range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (max_db_reg <= PEAK_DB_MAX))
    else $error("window peak in dB out of range");

endmodule

`default_nettype wire

### rtl/sonar_row_beam_profile.sv
// The result of a row appears on m_tvalid after the edge that accepts its last
// amplitude beat loads the input register; the row record and then the output
// register are loaded after it, and back-pressure can hold either of them.
// Throughput: one amplitude beat per cycle while the row record can be freed
// at the end of a row, else s_tready drops; one result per row.
// Reset clears the row state and all valid flags and loads the register defaults
// (96 beams, window of 4, scale 6143).
`default_nettype none

module sonar_row_beam_profile #(
    parameter int MAX_BEAMS  = srbp_pkg::MAX_BEAMS_DEF,
    parameter int MAX_WINDOW = srbp_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // amplitude[7:0]
    input  wire logic [srbp_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // center_mean_db[14:0], center_max_db[29:15], strongest_beam[36:30],
    // strongest_angle[46:37], zero fill [47]
    output logic [srbp_pkg::OUT_TDATA_W-1:0]       m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [srbp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [srbp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CW = $clog2(MAX_BEAMS);
    localparam int SW = $clog2(MAX_WINDOW * srbp_pkg::AMP_MAX + 1);

    logic [srbp_pkg::BEAMS_W-1:0]  number_of_beams_reg;
    logic [srbp_pkg::WINDOW_W-1:0] avg_beams_reg;
    logic [srbp_pkg::SCALE_W-1:0]  avg_scale_reg;

    logic                          rec_valid;
    logic                          rec_ready;
    logic [SW-1:0]                 rec_sum;
    logic [srbp_pkg::AMP_W-1:0]    rec_peak;
    logic [CW-1:0]                 rec_best;
    logic [CW-1:0]                 rec_half;
    logic                          rec_wide;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_of_beams_reg <= srbp_pkg::BEAMS_RESET;
            avg_beams_reg       <= srbp_pkg::WINDOW_RESET;
            avg_scale_reg       <= srbp_pkg::SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                srbp_pkg::REG_NUMBER_OF_BEAMS:
                begin
                    number_of_beams_reg <= cfg_data[srbp_pkg::BEAMS_W-1:0];
                end
                srbp_pkg::REG_AVG_BEAMS:
                begin
                    avg_beams_reg <= cfg_data[srbp_pkg::WINDOW_W-1:0];
                end
                srbp_pkg::REG_AVG_SCALE:
                begin
                    avg_scale_reg <= cfg_data[srbp_pkg::SCALE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    srbp_row_acc #(
        .MAX_BEAMS  (MAX_BEAMS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_row_acc (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .amplitude       (s_tdata[srbp_pkg::AMP_W-1:0]),
        .number_of_beams (number_of_beams_reg),
        .avg_beams       (avg_beams_reg),
        .rec_valid       (rec_valid),
        .rec_ready       (rec_ready),
        .rec_sum         (rec_sum),
        .rec_peak        (rec_peak),
        .rec_best        (rec_best),
        .rec_half        (rec_half),
        .rec_wide        (rec_wide)
    );

    srbp_result #(
        .MAX_BEAMS  (MAX_BEAMS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec_sum   (rec_sum),
        .rec_peak  (rec_peak),
        .rec_best  (rec_best),
        .rec_half  (rec_half),
        .rec_wide  (rec_wide),
        .avg_scale (avg_scale_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
